/* rtl/three_level_feedback_scheduler_defines.svh */
// Assertion macros for the three-level feedback scheduler
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TLFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlfs_pkg.sv */
// Types and constants shared by the three-level feedback scheduler files
`timescale 1ns / 1ps
package tlfs_pkg;

    localparam logic       FUNC_ARRIVE   = 1'b0;
    localparam logic       FUNC_TICK     = 1'b1;

    localparam logic [1:0] LVL_TOP       = 2'd0;
    localparam logic [1:0] LVL_MID       = 2'd1;
    localparam logic [1:0] LVL_BOT       = 2'd2;

    localparam logic [3:0] QUANTUM_RESET = 4'd4;
    localparam int         OUT_TDATA_W   = 48;

    typedef struct packed {
        logic [31:0] now;
        logic        finished;
        logic        first_run;
        logic [1:0]  level;
        logic [3:0]  ran_slot;
        logic        ran;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

/* rtl/tlfs_ram.sv */
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module tlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/three_level_feedback_scheduler.sv */
// Three-level feedback queue scheduler: top level with queue and slot memories
`timescale 1ns / 1ps
// An arrival beat (tuser 0) is taken in the idle state, and the block is ready again
// the next cycle. A tick beat (tuser 1) served from the top or bottom queue steps
// through queue read, slot read, then execute and result. A tick served from the
// middle list makes one pass through the list memory and slot memory to find the
// least remaining time, then one pass that closes the gap left by the chosen entry,
// then a slot read. An idle tick goes straight to execute and result.
// The result register lets the next beat in while a result waits, and
// a tick stalls in its last cycle only while an earlier result is still held.
module three_level_feedback_scheduler #(
    parameter int TASK_SLOTS = 16,
    parameter int BURST_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [3:0]                          i_cfg_data,   // quantum
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((4+BURST_BITS+7)/8)*8-1:0]   i_s_tdata,    // task_slot, burst
    input  logic [0:0]                          i_s_tuser,    // func
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // ran, ran_slot, level, first_run, finished, now
    output logic [tlfs_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int SW     = $clog2(TASK_SLOTS);
    localparam int CW     = $clog2(TASK_SLOTS + 1);
    localparam int SRAM_W = BURST_BITS + 5;

    typedef enum logic [2:0] {
        S_IDLE, S_FIFO, S_SCAN, S_SHIFT, S_RDSLOT, S_EXEC
    } t_state;

    t_state              r_state;
    logic [3:0]          r_quantum;
    logic [TASK_SLOTS-1:0] r_occ;
    logic [SW-1:0]       r_top_head, r_bot_head;
    logic [CW-1:0]       r_top_cnt, r_bot_cnt, r_mid_cnt;
    logic [31:0]         r_time;
    logic [1:0]          r_lvl;
    logic                r_run;
    logic [SW-1:0]       r_slot;
    logic [CW-1:0]       r_ri;
    logic                r_v1, r_v2, r_rv;
    logic [SW-1:0]       r_p1, r_p2, r_s2, r_best_pos, r_wa;
    logic [BURST_BITS-1:0] r_best_rem;
    logic                r_out_valid;
    tlfs_pkg::t_result   r_out;

    logic                  w_s_acc, w_func, w_in_range, w_arr, w_exec;
    logic [3:0]            w_slot_in;
    logic [SW-1:0]         w_idx;
    logic [BURST_BITS-1:0] w_burst;
    logic [SW-1:0]         w_top_tail, w_bot_tail;
    logic [CW:0]           w_top_sum, w_bot_sum;

    logic                  w_sl_we;
    logic [SW-1:0]         w_sl_waddr, w_sl_raddr;
    logic [SRAM_W-1:0]     w_sl_wdata, w_sl_rdata;
    logic                  w_top_we, w_mid_we, w_bot_we;
    logic [SW-1:0]         w_top_wdata, w_mid_waddr, w_mid_wdata;
    logic [SW-1:0]         w_top_rdata, w_mid_rdata, w_bot_rdata;

    logic [BURST_BITS-1:0] w_rem, w_rem1;
    logic [3:0]            w_slice, w_slice1, w_slice_new;
    logic                  w_started, w_fin, w_demote;
    logic                  w_push_top, w_push_mid, w_push_bot;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(tlfs_pkg::OUT_TDATA_W - tlfs_pkg::RESULT_W){1'b0}}, r_out};

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_func     = i_s_tuser[0];
    assign w_slot_in  = i_s_tdata[3:0];
    assign w_burst    = i_s_tdata[4 +: BURST_BITS];
    assign w_in_range = (32'(w_slot_in) < TASK_SLOTS);
    assign w_idx      = SW'(w_slot_in);
    assign w_arr      = w_s_acc && (w_func == tlfs_pkg::FUNC_ARRIVE) && w_in_range
                        && !r_occ[w_idx] && (w_burst != '0);
    assign w_exec     = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    always_comb begin
        w_top_sum = (CW+1)'(r_top_head) + (CW+1)'(r_top_cnt);
        w_bot_sum = (CW+1)'(r_bot_head) + (CW+1)'(r_bot_cnt);
        w_top_tail = (w_top_sum >= (CW+1)'(TASK_SLOTS))
                     ? SW'(w_top_sum - (CW+1)'(TASK_SLOTS)) : SW'(w_top_sum);
        w_bot_tail = (w_bot_sum >= (CW+1)'(TASK_SLOTS))
                     ? SW'(w_bot_sum - (CW+1)'(TASK_SLOTS)) : SW'(w_bot_sum);
    end

    assign w_rem     = w_sl_rdata[SRAM_W-1:5];
    assign w_slice   = w_sl_rdata[4:1];
    assign w_started = w_sl_rdata[0];
    assign w_rem1    = w_rem - BURST_BITS'(1);
    assign w_fin     = (w_rem1 == '0);
    assign w_slice1  = w_slice + 4'd1;
    assign w_demote  = (r_lvl == tlfs_pkg::LVL_TOP) && (w_slice1 == r_quantum);

    always_comb begin
        if (r_lvl != tlfs_pkg::LVL_TOP) begin
            w_slice_new = w_slice;
        end else if (w_demote && !w_fin) begin
            w_slice_new = 4'd0;
        end else begin
            w_slice_new = w_slice1;
        end
    end

    assign w_push_top = w_exec && r_run && !w_fin && (r_lvl == tlfs_pkg::LVL_TOP) && !w_demote;
    assign w_push_mid = w_exec && r_run && !w_fin && w_demote;
    assign w_push_bot = w_exec && r_run && !w_fin && (r_lvl != tlfs_pkg::LVL_TOP);

    always_comb begin
        w_sl_we    = w_arr || (w_exec && r_run);
        w_sl_waddr = w_arr ? w_idx : r_slot;
        w_sl_wdata = w_arr ? {w_burst, 4'd0, 1'b0} : {w_rem1, w_slice_new, 1'b1};
        unique case (r_state)
            S_FIFO:  w_sl_raddr = (r_lvl == tlfs_pkg::LVL_TOP) ? w_top_rdata : w_bot_rdata;
            S_SCAN:  w_sl_raddr = w_mid_rdata;
            default: w_sl_raddr = r_slot;
        endcase

        w_top_we    = w_arr || w_push_top;
        w_top_wdata = w_arr ? w_idx : r_slot;
        w_bot_we    = w_push_bot;

        if (r_state == S_SHIFT && r_rv) begin
            w_mid_we    = 1'b1;
            w_mid_waddr = r_wa;
            w_mid_wdata = w_mid_rdata;
        end else begin
            w_mid_we    = w_push_mid;
            w_mid_waddr = SW'(r_mid_cnt);
            w_mid_wdata = r_slot;
        end
    end

    tlfs_ram #(.WIDTH(SRAM_W), .DEPTH(TASK_SLOTS)) u_slot_ram (
        .i_clk, .i_we(w_sl_we), .i_waddr(w_sl_waddr), .i_wdata(w_sl_wdata),
        .i_raddr(w_sl_raddr), .o_rdata(w_sl_rdata)
    );

    tlfs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_top_ram (
        .i_clk, .i_we(w_top_we), .i_waddr(w_top_tail), .i_wdata(w_top_wdata),
        .i_raddr(r_top_head), .o_rdata(w_top_rdata)
    );

    tlfs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_mid_ram (
        .i_clk, .i_we(w_mid_we), .i_waddr(w_mid_waddr), .i_wdata(w_mid_wdata),
        .i_raddr(r_ri[SW-1:0]), .o_rdata(w_mid_rdata)
    );

    tlfs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_bot_ram (
        .i_clk, .i_we(w_bot_we), .i_waddr(w_bot_tail), .i_wdata(r_slot),
        .i_raddr(r_bot_head), .o_rdata(w_bot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= tlfs_pkg::QUANTUM_RESET;
            r_occ       <= '0;
            r_top_head  <= '0;
            r_top_cnt   <= '0;
            r_bot_head  <= '0;
            r_bot_cnt   <= '0;
            r_mid_cnt   <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_rv        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_arr) begin
                        r_occ[w_idx] <= 1'b1;
                        r_top_cnt    <= r_top_cnt + CW'(1);
                    end
                    if (w_s_acc && w_func == tlfs_pkg::FUNC_TICK) begin
                        priority if (r_top_cnt != '0) begin
                            r_run      <= 1'b1;
                            r_lvl      <= tlfs_pkg::LVL_TOP;
                            r_top_head <= (r_top_head == SW'(TASK_SLOTS - 1))
                                          ? '0 : r_top_head + SW'(1);
                            r_top_cnt  <= r_top_cnt - CW'(1);
                            r_state    <= S_FIFO;
                        end else if (r_mid_cnt != '0) begin
                            r_run   <= 1'b1;
                            r_lvl   <= tlfs_pkg::LVL_MID;
                            r_ri    <= '0;
                            r_v1    <= 1'b0;
                            r_v2    <= 1'b0;
                            r_state <= S_SCAN;
                        end else if (r_bot_cnt != '0) begin
                            r_run      <= 1'b1;
                            r_lvl      <= tlfs_pkg::LVL_BOT;
                            r_bot_head <= (r_bot_head == SW'(TASK_SLOTS - 1))
                                          ? '0 : r_bot_head + SW'(1);
                            r_bot_cnt  <= r_bot_cnt - CW'(1);
                            r_state    <= S_FIFO;
                        end else begin
                            r_lvl   <= tlfs_pkg::LVL_TOP;
                            r_run   <= 1'b0;
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_FIFO: begin
                    r_slot  <= w_sl_raddr;
                    r_state <= S_EXEC;
                end
                S_SCAN: begin
                    r_v1 <= (r_ri < r_mid_cnt);
                    if (r_ri < r_mid_cnt) begin
                        r_p1 <= r_ri[SW-1:0];
                        r_ri <= r_ri + CW'(1);
                    end
                    r_v2 <= r_v1;
                    r_p2 <= r_p1;
                    r_s2 <= w_mid_rdata;
                    if (r_v2 && (r_p2 == '0 || w_rem < r_best_rem)) begin
                        r_best_rem <= w_rem;
                        r_best_pos <= r_p2;
                        r_slot     <= r_s2;
                    end
                    if (r_ri >= r_mid_cnt && !r_v1 && !r_v2) begin
                        r_ri    <= CW'(r_best_pos) + CW'(1);
                        r_rv    <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_ri < r_mid_cnt) begin
                        r_rv <= 1'b1;
                        r_wa <= SW'(r_ri - CW'(1));
                        r_ri <= r_ri + CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_ri >= r_mid_cnt && !r_rv) begin
                        r_mid_cnt <= r_mid_cnt - CW'(1);
                        r_state   <= S_RDSLOT;
                    end
                end
                S_RDSLOT: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_exec) begin
                        r_out.now       <= r_time;
                        r_out.ran       <= r_run;
                        r_out.ran_slot  <= r_run ? 4'(r_slot) : 4'd0;
                        r_out.level     <= r_run ? r_lvl : tlfs_pkg::LVL_TOP;
                        r_out.first_run <= r_run && !w_started;
                        r_out.finished  <= r_run && w_fin;
                        r_time          <= r_time + 32'd1;
                        if (r_run && w_fin) begin
                            r_occ[r_slot] <= 1'b0;
                        end
                        if (w_push_top) begin
                            r_top_cnt <= r_top_cnt + CW'(1);
                        end
                        if (w_push_mid) begin
                            r_mid_cnt <= r_mid_cnt + CW'(1);
                        end
                        if (w_push_bot) begin
                            r_bot_cnt <= r_bot_cnt + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/tlfs_checker.sv */
// Port-level assertion checker for the three-level feedback scheduler
`timescale 1ns / 1ps
`include "three_level_feedback_scheduler_defines.svh"
module tlfs_checker #(
    parameter int BURST_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [3:0]                        i_cfg_data,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [((4+BURST_BITS+7)/8)*8-1:0] i_s_tdata,
    input logic [0:0]                        i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [tlfs_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    tlfs_pkg::t_result w_res;
    logic              w_beat;
    logic              r_seen;
    logic [31:0]       r_last_now;

    assign w_res  = o_m_tdata[tlfs_pkg::RESULT_W-1:0];
    assign w_beat = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_beat) begin
            r_seen     <= 1'b1;
            r_last_now <= w_res.now;
        end
    end

    `TLFS_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")
    `TLFS_ASSERT_SAME(a_time_step, w_beat && r_seen, w_res.now == r_last_now + 32'd1, "time did not advance by one between results")
    `TLFS_ASSERT_SAME(a_idle_zero, o_m_tvalid && !w_res.ran, w_res.ran_slot == 4'd0 && w_res.level == tlfs_pkg::LVL_TOP && !w_res.first_run && !w_res.finished, "idle tick reports a task")
    `TLFS_ASSERT_SAME(a_level_code, o_m_tvalid, w_res.level == tlfs_pkg::LVL_TOP || w_res.level == tlfs_pkg::LVL_MID || w_res.level == tlfs_pkg::LVL_BOT, "bad level code")

endmodule

bind three_level_feedback_scheduler tlfs_checker #(.BURST_BITS(BURST_BITS)) u_tlfs_checker (.*);

/* tb/sv/three_level_feedback_scheduler_checker.sv */
// Checker for the three-level feedback scheduler: schedule predictor and result compare
`timescale 1ns / 1ps
module three_level_feedback_scheduler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_ticks,
    output int          o_runs
);

    logic [3:0]  quantum_q;
    logic [15:0] rem_left [16];
    logic [3:0]  slice_cnt [16];
    logic        has_run [16];
    logic        busy_slot [16];
    logic [3:0]  top_q [$];
    logic [3:0]  mid_q [$];
    logic [3:0]  bot_q [$];
    logic [31:0] clock_now;
    tlfs_pkg::t_result sched_expect [$];

    task automatic admit_task(input logic [3:0] slot, input logic [15:0] burst);
        if (!busy_slot[slot] && burst != 0) begin
            busy_slot[slot] = 1'b1;
            rem_left[slot]  = burst;
            slice_cnt[slot] = '0;
            has_run[slot]   = 1'b0;
            top_q = {top_q, slot};
        end
    endtask

    function automatic tlfs_pkg::t_result run_tick();
        tlfs_pkg::t_result r;
        int best;
        logic [3:0] s;
        r = '0;
        s = '0;
        r.now = clock_now;
        if (top_q.size() > 0) begin
            s = top_q.pop_front();
            r.level = tlfs_pkg::LVL_TOP;
            r.ran = 1'b1;
        end else if (mid_q.size() > 0) begin
            best = 0;
            for (int i = 1; i < mid_q.size(); i++)
                if (rem_left[mid_q[i]] < rem_left[mid_q[best]]) best = i;
            s = mid_q[best];
            mid_q.delete(best);
            r.level = tlfs_pkg::LVL_MID;
            r.ran = 1'b1;
        end else if (bot_q.size() > 0) begin
            s = bot_q.pop_front();
            r.level = tlfs_pkg::LVL_BOT;
            r.ran = 1'b1;
        end
        if (r.ran) begin
            r.ran_slot  = s;
            r.first_run = !has_run[s];
            has_run[s]  = 1'b1;
            rem_left[s] = rem_left[s] - 16'd1;
            if (r.level == tlfs_pkg::LVL_TOP) slice_cnt[s] = slice_cnt[s] + 4'd1;
            if (rem_left[s] == 0) begin
                r.finished   = 1'b1;
                busy_slot[s] = 1'b0;
            end else if (r.level == tlfs_pkg::LVL_TOP) begin
                if (slice_cnt[s] == quantum_q) begin
                    slice_cnt[s] = '0;
                    mid_q = {mid_q, s};
                end else begin
                    top_q = {top_q, s};
                end
            end else begin
                bot_q = {bot_q, s};
            end
        end
        clock_now = clock_now + 32'd1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        tlfs_pkg::t_result got, want;
        if (!i_rst_n) begin
            quantum_q = tlfs_pkg::QUANTUM_RESET;
            clock_now = '0;
            for (int i = 0; i < 16; i++) begin
                rem_left[i] = '0; slice_cnt[i] = '0;
                has_run[i] = 1'b0; busy_slot[i] = 1'b0;
            end
            top_q.delete(); mid_q.delete(); bot_q.delete();
            sched_expect.delete();
            o_errors = 0; o_ticks = 0; o_runs = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) quantum_q = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == tlfs_pkg::FUNC_TICK) begin
                    sched_expect = {sched_expect, run_tick()};
                    o_ticks++;
                end else begin
                    admit_task(i_s_tdata[3:0], i_s_tdata[19:4]);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = tlfs_pkg::t_result'(i_m_tdata[tlfs_pkg::RESULT_W-1:0]);
                if (sched_expect.size() == 0) begin
                    $error("result beat with nothing expected: %h", i_m_tdata);
                    o_errors++;
                end else begin
                    want = sched_expect.pop_front();
                    if (want.ran) o_runs++;
                    if (got.ran != want.ran) begin
                        $error("ran: expected %0d got %0d", want.ran, got.ran); o_errors++;
                    end
                    if (got.ran_slot != want.ran_slot) begin
                        $error("ran_slot: expected %0d got %0d", want.ran_slot, got.ran_slot);
                        o_errors++;
                    end
                    if (got.level != want.level) begin
                        $error("level: expected %0d got %0d", want.level, got.level);
                        o_errors++;
                    end
                    if (got.first_run != want.first_run) begin
                        $error("first_run: expected %0d got %0d", want.first_run,
                               got.first_run);
                        o_errors++;
                    end
                    if (got.finished != want.finished) begin
                        $error("finished: expected %0d got %0d", want.finished,
                               got.finished);
                        o_errors++;
                    end
                    if (got.now != want.now) begin
                        $error("now: expected %0d got %0d", want.now, got.now); o_errors++;
                    end
                end
            end
        end
        o_pending = sched_expect.size();
    end
endmodule

/* tb/sv/three_level_feedback_scheduler_test.sv */
// Testbench top for the three-level feedback scheduler: stimulus, reset and verdict
`timescale 1ns / 1ps
module three_level_feedback_scheduler_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // task_slot, burst, zero pad
    logic [0:0]  i_s_tuser;   // func
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // ran, ran_slot, level, first_run, finished, now
    int          fail_count, pending, tick_count, run_count;
    logic        calm;

    three_level_feedback_scheduler dut (.*);

    three_level_feedback_scheduler_checker chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .o_errors(fail_count), .o_pending(pending), .o_ticks(tick_count),
        .o_runs(run_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    // randomly stall the result side, except in calm stretches
    always @(posedge i_clk)
        i_m_tready <= calm || ($urandom_range(0, 99) >= 25);

    task automatic send_beat(input logic f, input logic [3:0] slot, input logic [15:0] b);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {4'd0, b, slot};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic arrive(input logic [3:0] slot, input logic [15:0] b);
        send_beat(tlfs_pkg::FUNC_ARRIVE, slot, b);
    endtask

    task automatic tick();
        send_beat(tlfs_pkg::FUNC_TICK, 4'($urandom()), 16'($urandom()));
    endtask

    task automatic set_quantum(input logic [3:0] q);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= q;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 30)
                arrive(4'($urandom()), $urandom_range(0, 9) == 0 ? 16'($urandom())
                       : 16'($urandom_range(0, 12)));
            else
                tick();
        end
        // no drain: the loop below never runs, since the tick count is never negative
        while (tick_count < 0) tick();
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = '0; i_m_tready = 1'b0;
        calm = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // idle tick, extremes, busy slot, zero burst, demotion to the middle list
        tick();
        arrive(4'd0, 16'd1);
        arrive(4'd15, 16'hFFFF);
        arrive(4'd15, 16'd3);
        arrive(4'd7, 16'd0);
        arrive(4'd3, 16'd6);
        arrive(4'd9, 16'd6);
        arrive(4'd5, 16'd5);
        repeat (16) tick();
        set_quantum(4'd1);
        arrive(4'd0, 16'd2);
        arrive(4'd1, 16'd2);
        repeat (4) tick();
        calm = 1'b0;
        random_phase(450);
        set_quantum(4'd15);
        random_phase(450);
        set_quantum(4'd0);
        calm = 1'b1;
        random_phase(150);
        calm = 1'b0;
        random_phase(300);
        set_quantum(4'($urandom_range(2, 14)));
        random_phase(450);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d ticks, %0d with a task running, quanta 4, 1, 15, 0, random",
                 tick_count, run_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* three_level_feedback_scheduler.f */
+incdir+rtl
rtl/tlfs_pkg.sv
rtl/tlfs_ram.sv
rtl/three_level_feedback_scheduler.sv
rtl/tlfs_checker.sv
tb/sv/three_level_feedback_scheduler_checker.sv
tb/sv/three_level_feedback_scheduler_test.sv
